// ===== rtl/cae_pkg.sv =====
package cae_pkg;

	// Reference store geometry. The cell index addresses the store modulo its depth.
	localparam int MAX_CELLS = 4096;
	localparam int CELL_AW   = $clog2(MAX_CELLS);

	// Field widths.
	localparam int CELL_W  = 12;
	localparam int COORD_W = 32;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int AREA_W  = 64;
	localparam int JAC_W   = 32;
	localparam int STAT_W  = 2;
	localparam int ACC_W   = 128;

	// Stream payload widths.
	localparam int IN_DATA_W  = 80;
	localparam int OUT_USED_W = CELL_W + AREA_W + JAC_W + STAT_W;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// Work queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_REF_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT      = 2'd2;

	// Saturation limits.
	localparam logic [AREA_W-1:0] AREA_MAX    = {1'b0, {(AREA_W-1){1'b1}}};
	localparam logic [AREA_W-1:0] AREA_MIN    = {1'b1, {(AREA_W-1){1'b0}}};
	localparam logic [JAC_W-1:0]  JAC_POS_LIM = {1'b0, {(JAC_W-1){1'b1}}};
	localparam logic [JAC_W-1:0]  JAC_NEG_LIM = {1'b1, {(JAC_W-1){1'b0}}};

	// One unit of work: add the cross term ax*by - ay*bx to the accumulator.
	// clr starts a new polygon, fin closes it and produces a result.
	typedef struct packed {
		logic                      clr;
		logic                      fin;
		logic                      cmd;
		logic [CELL_W-1:0]         cell_idx;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
	} cae_entry_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_idx;
		logic [AREA_W-1:0] area;
		logic [JAC_W-1:0]  jac;
		logic [STAT_W-1:0] status;
	} cae_result_t;

endpackage

// ===== rtl/cell_area_jacobian_engine.sv =====
// Cell area and Jacobian engine. Each input transfer carries one polygon vertex in signed
// Q16.16; tlast marks the final vertex of a polygon, and the cell index and command
// (tuser: 0 stores the area as the cell's reference, 1 also returns new area over reference
// area in Q16.16 and then replaces the reference) are taken from that last vertex. Exactly
// one output transfer follows each last vertex, giving the cell index, the signed shoelace
// area in Q32.32 (saturated), the Jacobian (zero for command 0 and for a zero reference) and
// a status: 0 ok, 1 reference area zero, 2 saturated. The front accepts up to one vertex per
// cycle while its four-entry work queue has room, and pauses after each last vertex that
// closes a multi-vertex polygon until its closing entry is pushed. The back takes one queue
// entry at a time through B_MUL_A, B_MUL_B and B_ACC (one 32x32 multiplier used twice per
// cross term, then a 128-bit accumulate); a closing entry then passes B_AREA and B_JAC, and
// a command 1 result with a nonzero reference and an unsaturated ratio also passes B_DIV, a
// one-bit-per-cycle divider, and B_FIN, before B_OUT. Reference areas live in a 4096 x 64
// single-port-read RAM with no clearing pass: a cell must receive a command 0 polygon
// before its first command 1 polygon. The cell index addresses that RAM modulo its depth.
module cell_area_jacobian_engine import cae_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: cell_index[11:0], vertex_x[43:12], vertex_y[75:44], zero pad.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: cmd.
	input  logic                  s_axis_tuser,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: cell_id_out[11:0], signed_area[75:12], jacobian[107:76],
	// status[109:108], zero pad.
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	cae_entry_t  push_entry;
	cae_entry_t  head;
	cae_result_t result;
	logic        push;
	logic        full;
	logic        pop;
	logic        empty;

	// The front tracks the polygon and turns vertices into cross-term work entries.
	cae_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.cmd        (s_axis_tuser),
		.cell_index (s_axis_tdata[CELL_W-1:0]),
		.vertex_x   (s_axis_tdata[CELL_W+COORD_W-1:CELL_W]),
		.vertex_y   (s_axis_tdata[CELL_W+2*COORD_W-1:CELL_W+COORD_W]),
		.last_vertex(s_axis_tlast),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// The queue lets vertices keep arriving while the back multiplies or divides.
	cae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// The back accumulates, closes the polygon, divides and holds the output register.
	cae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.result   (result)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result.status, result.jac, result.area,
		result.cell_idx};

endmodule

// ===== rtl/cae_ram.sv =====
module cae_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/cae_queue.sv =====
module cae_queue import cae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cae_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output cae_entry_t head,
	output logic       empty
);

	cae_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/cae_front.sv =====
module cae_front import cae_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [CELL_W-1:0]         cell_index,
	input  logic signed [COORD_W-1:0] vertex_x,
	input  logic signed [COORD_W-1:0] vertex_y,
	input  logic                      last_vertex,
	output logic                      push,
	output cae_entry_t                push_entry,
	input  logic                      full
);

	logic                      in_poly_q;
	logic                      pend_q;
	logic                      pend_cmd_q;
	logic [CELL_W-1:0]         pend_cell_q;
	logic signed [COORD_W-1:0] first_x_q;
	logic signed [COORD_W-1:0] first_y_q;
	logic signed [COORD_W-1:0] prev_x_q;
	logic signed [COORD_W-1:0] prev_y_q;
	logic                      accept;

	// A closing vertex needs a second entry, so input pauses until that entry is pushed.
	assign in_ready = !pend_q && !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push                = 1'b0;
		push_entry.clr      = 1'b0;
		push_entry.fin      = 1'b0;
		push_entry.cmd      = cmd;
		push_entry.cell_idx = cell_index;
		push_entry.ax       = prev_x_q;
		push_entry.ay       = prev_y_q;
		push_entry.bx       = vertex_x;
		push_entry.by       = vertex_y;
		if (pend_q) begin
			push                = !full;
			push_entry.fin      = 1'b1;
			push_entry.cmd      = pend_cmd_q;
			push_entry.cell_idx = pend_cell_q;
			push_entry.bx       = first_x_q;
			push_entry.by       = first_y_q;
		end else if (accept) begin
			push = 1'b1;
			if (!in_poly_q) begin
				// First vertex: the cross term of a point with itself is zero.
				push_entry.clr = 1'b1;
				push_entry.fin = last_vertex;
				push_entry.ax  = vertex_x;
				push_entry.ay  = vertex_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (accept) begin
				if (!in_poly_q) begin
					in_poly_q <= !last_vertex;
				end else if (last_vertex) begin
					in_poly_q <= 1'b0;
					pend_q    <= 1'b1;
				end
			end
			if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q    <= vertex_x;
			prev_y_q    <= vertex_y;
			pend_cmd_q  <= cmd;
			pend_cell_q <= cell_index;
			if (!in_poly_q) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
		end
	end

endmodule

// ===== rtl/cae_back.sv =====
module cae_back import cae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cae_entry_t  head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output cae_result_t result
);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_MUL_A = 4'd1;
	localparam logic [3:0] B_MUL_B = 4'd2;
	localparam logic [3:0] B_ACC   = 4'd3;
	localparam logic [3:0] B_AREA  = 4'd4;
	localparam logic [3:0] B_JAC   = 4'd5;
	localparam logic [3:0] B_DIV   = 4'd6;
	localparam logic [3:0] B_FIN   = 4'd7;
	localparam logic [3:0] B_OUT   = 4'd8;

	logic [3:0]               state_q;
	cae_entry_t               ent_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]         acc_q;
	logic [AREA_W-1:0]        area_q;
	logic [STAT_W-1:0]        status_q;
	logic [JAC_W-1:0]         jac_q;
	logic                     neg_q;
	logic [AREA_W-1:0]        ur_q;
	logic [AREA_W-1:0]        rem_q;
	logic [JAC_W-1:0]         dvd_q;
	logic [JAC_W-1:0]         quo_q;
	logic [4:0]               cnt_q;
	logic                     out_valid_q;
	cae_result_t              out_q;

	logic                     ram_re;
	logic                     ram_we;
	logic [AREA_W-1:0]        ref_area;
	logic                     can_out;
	logic                     area_fits;
	logic [AREA_W-1:0]        ua;
	logic [AREA_W-1:0]        ur;
	logic                     quo_big;
	logic [AREA_W:0]          r2;
	logic [AREA_W:0]          r2_diff;
	logic [JAC_W-1:0]         limit;
	logic                     jac_sat;
	logic [JAC_W-1:0]         mag;

	assign pop       = (state_q == B_IDLE) && !empty;
	assign can_out   = !out_valid_q || out_ready;
	assign ram_re    = (state_q == B_MUL_A) && ent_q.fin;
	assign ram_we    = (state_q == B_OUT) && can_out;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	cae_ram #(
		.WIDTH(AREA_W),
		.DEPTH(MAX_CELLS)
	) u_ref_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ent_q.cell_idx[CELL_AW-1:0]),
		.wdata(area_q),
		.re   (ram_re),
		.raddr(ent_q.cell_idx[CELL_AW-1:0]),
		.rdata(ref_area)
	);

	// The half sum fits in 64 bits when the accumulator's upper half is a sign extension.
	assign area_fits = (&acc_q[ACC_W-1:AREA_W]) || !(|acc_q[ACC_W-1:AREA_W]);
	assign ua        = area_q[AREA_W-1] ? (~area_q + 1'b1) : area_q;
	assign ur        = ref_area[AREA_W-1] ? (~ref_area + 1'b1) : ref_area;
	// An integer part of the ratio of 2^16 or more saturates whatever the sign.
	assign quo_big   = {16'd0, ua} >= {ur, 16'd0};
	assign r2        = {rem_q, dvd_q[JAC_W-1]};
	assign r2_diff   = r2 - {1'b0, ur_q};
	assign limit     = neg_q ? JAC_NEG_LIM : JAC_POS_LIM;
	assign jac_sat   = quo_q > limit;
	assign mag       = jac_sat ? limit : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result is only loaded from B_OUT, which sets the valid itself.
			if (out_valid_q && out_ready && (state_q != B_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= B_MUL_A;
					end
				end
				B_MUL_A: state_q <= B_MUL_B;
				B_MUL_B: state_q <= B_ACC;
				B_ACC:   state_q <= ent_q.fin ? B_AREA : B_IDLE;
				B_AREA:  state_q <= B_JAC;
				B_JAC: begin
					if (ent_q.cmd && (ref_area != '0) && !quo_big) begin
						state_q <= B_DIV;
					end else begin
						state_q <= B_OUT;
					end
				end
				B_DIV: begin
					if (cnt_q == 5'(JAC_W - 1)) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: state_q <= B_OUT;
				B_OUT: begin
					if (can_out) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					ent_q <= head;
				end
			end
			B_MUL_A: begin
				prod_q <= ent_q.ax * ent_q.by;
			end
			B_MUL_B: begin
				acc_q  <= (ent_q.clr ? '0 : acc_q) + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
				prod_q <= ent_q.ay * ent_q.bx;
			end
			B_ACC: begin
				acc_q <= acc_q - {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
			end
			B_AREA: begin
				if (area_fits) begin
					area_q   <= acc_q[AREA_W:1];
					status_q <= ST_OK;
				end else begin
					area_q   <= acc_q[ACC_W-1] ? AREA_MIN : AREA_MAX;
					status_q <= ST_SAT;
				end
			end
			B_JAC: begin
				jac_q <= '0;
				neg_q <= area_q[AREA_W-1] ^ ref_area[AREA_W-1];
				ur_q  <= ur;
				rem_q <= {16'd0, ua[AREA_W-1:16]};
				dvd_q <= {ua[15:0], 16'd0};
				quo_q <= '0;
				cnt_q <= '0;
				if (ent_q.cmd) begin
					if (ref_area == '0) begin
						status_q <= ST_REF_ZERO;
					end else if (quo_big) begin
						jac_q    <= (area_q[AREA_W-1] ^ ref_area[AREA_W-1]) ? JAC_NEG_LIM
							: JAC_POS_LIM;
						status_q <= ST_SAT;
					end
				end
			end
			B_DIV: begin
				// One restoring division step per cycle.
				if (r2 >= {1'b0, ur_q}) begin
					rem_q <= r2_diff[AREA_W-1:0];
					quo_q <= {quo_q[JAC_W-2:0], 1'b1};
				end else begin
					rem_q <= r2[AREA_W-1:0];
					quo_q <= {quo_q[JAC_W-2:0], 1'b0};
				end
				dvd_q <= {dvd_q[JAC_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			B_FIN: begin
				jac_q <= neg_q ? (~mag + 1'b1) : mag;
				if (jac_sat) begin
					status_q <= ST_SAT;
				end
			end
			B_OUT: begin
				if (can_out) begin
					out_q.cell_idx <= ent_q.cell_idx;
					out_q.area     <= area_q;
					out_q.jac      <= jac_q;
					out_q.status   <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/cae_checker.sv =====
module cae_checker import cae_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  s_axis_tuser,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [STAT_W-1:0] st;
	logic [JAC_W-1:0]  jac;
	logic [AREA_W-1:0] area;

	assign st   = m_axis_tdata[OUT_USED_W-1:OUT_USED_W-STAT_W];
	assign jac  = m_axis_tdata[CELL_W+AREA_W+JAC_W-1:CELL_W+AREA_W];
	assign area = m_axis_tdata[CELL_W+AREA_W-1:CELL_W];

	// A result waiting for its transfer stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (st == ST_OK || st == ST_REF_ZERO || st == ST_SAT))
		else $error("undefined status code");

	a_ref_zero_jac: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == ST_REF_ZERO |-> jac == '0)
		else $error("nonzero jacobian with zero reference");

	// A saturated status with an unsaturated ratio means the area itself saturated.
	a_sat_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == ST_SAT && jac != JAC_POS_LIM && jac != JAC_NEG_LIM
		|-> area == AREA_MAX || area == AREA_MIN)
		else $error("saturated status without a saturated field");

endmodule

bind cell_area_jacobian_engine cae_checker u_cae_checker (.*);
